>>> rtl/core/depth_window_average_colorizer_unit_defines.svh
// Assertion macros for the checker file of the depth colouriser.
`ifndef DEPTH_WINDOW_AVERAGE_COLORIZER_UNIT_DEFINES_SVH
`define DEPTH_WINDOW_AVERAGE_COLORIZER_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst is high.
`define DWAC_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst is high.
`define DWAC_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/dwac_pkg.sv
// Types, register codes and constants of the depth window colouriser.
package dwac_pkg;

  localparam int PIX_W      = 8;
  localparam int POS_W      = 19;
  localparam int POS_CMP_W  = 21;
  localparam int WIN_W      = 5;
  localparam int CFG_IDX_W  = 3;
  localparam int DIV_NUM_W  = 16;
  localparam int DIV_DEN_W  = 8;
  localparam int DIV_CNT_W  = 3;

  localparam logic [PIX_W-1:0] SCALE_MAX = 8'd255;

  typedef struct packed {
    logic [PIX_W-1:0] depth_raw;
    logic [POS_W-1:0] pixel_pos;
    logic             frame_end;
  } pix_in_t;

  typedef struct packed {
    logic [PIX_W-1:0] red;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] blue;
  } pix_out_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FAR   = 3'd0,
    CFG_NEAR  = 3'd1,
    CFG_WIN   = 3'd2,
    CFG_WATER = 3'd3,
    CFG_GRASS = 3'd4,
    CFG_HILL  = 3'd5,
    CFG_MODE  = 3'd6
  } cfg_idx_t;

  localparam logic [PIX_W-1:0] FAR_RST   = 8'd150;
  localparam logic [PIX_W-1:0] NEAR_RST  = 8'd161;
  localparam logic [WIN_W-1:0] WIN_RST   = 5'd1;
  localparam logic [PIX_W-1:0] WATER_RST = 8'd26;
  localparam logic [PIX_W-1:0] GRASS_RST = 8'd128;
  localparam logic [PIX_W-1:0] HILL_RST  = 8'd128;
  localparam logic             MODE_RST  = 1'b0;

  localparam logic MODE_GRAY = 1'b0;

  localparam pix_out_t WATER_RGB = '{red: 8'd95,  green: 8'd145, blue: 8'd226};
  localparam pix_out_t GRASS_RGB = '{red: 8'd77,  green: 8'd198, blue: 8'd47};
  localparam pix_out_t HILL_RGB  = '{red: 8'd127, green: 8'd93,  blue: 8'd15};
  localparam pix_out_t PEAK_RGB  = '{red: 8'd247, green: 8'd245, blue: 8'd239};
  localparam pix_out_t EDGE_RGB  = '{red: 8'd255, green: 8'd255, blue: 8'd255};
  localparam pix_out_t BLACK_RGB = '{red: 8'd0,   green: 8'd0,   blue: 8'd0};

  // controller -> datapath
  typedef struct packed {
    logic clr_step;
    logic take;
    logic rd;
    logic div_scale;
    logic row_upd;
    logic acc_step;
    logic div_mean;
    logic out_load;
  } dwac_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic clr_last;
    logic pos_ok;
    logic div_done;
    logic acc_last;
    logic out_free;
  } dwac_stat_t;

endpackage

>>> rtl/core/dwac_divider.sv
// Shared restoring divider, one quotient bit per cycle, 8-bit quotient.
module dwac_divider
  import dwac_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [DIV_NUM_W-1:0] numer,
  input  logic [DIV_DEN_W-1:0] denom,
  output logic                 done,
  output logic [PIX_W-1:0]     quot
);

  logic                 busy;
  logic [DIV_CNT_W-1:0] cnt;
  logic [DIV_NUM_W-1:0] rem;
  logic [DIV_DEN_W-1:0] den;
  logic [DIV_NUM_W-1:0] shifted;
  logic                 fits;

  // caller guarantees quotient < 256
  assign shifted = DIV_NUM_W'(den) << cnt;
  assign fits    = rem >= shifted;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= DIV_CNT_W'(PIX_W - 1);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= numer;
      den  <= denom;
      quot <= '0;
    end else if (busy && fits) begin
      rem       <= rem - shifted;
      quot[cnt] <= 1'b1;
    end
  end

endmodule

>>> rtl/core/dwac_ctrl.sv
// Sequencing state machine of the depth colouriser.
module dwac_ctrl
  import dwac_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  dwac_stat_t stat,
  output dwac_cmd_t  cmd
);

  typedef enum logic [8:0] {
    S_CLEAR = 9'b000000001,
    S_IDLE  = 9'b000000010,
    S_READ  = 9'b000000100,
    S_SCALE = 9'b000001000,
    S_WRITE = 9'b000010000,
    S_ACCUM = 9'b000100000,
    S_DIVM  = 9'b001000000,
    S_WAITM = 9'b010000000,
    S_FIN   = 9'b100000000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (stat.clr_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.take   = 1'b1;
          state_next = S_READ;
        end
      end
      S_READ: begin
        cmd.rd        = 1'b1;
        cmd.div_scale = stat.pos_ok;
        state_next    = stat.pos_ok ? S_SCALE : S_FIN;
      end
      S_SCALE: begin
        if (stat.div_done) state_next = S_WRITE;
      end
      S_WRITE: begin
        cmd.row_upd = 1'b1;
        state_next  = S_ACCUM;
      end
      S_ACCUM: begin
        cmd.acc_step = 1'b1;
        if (stat.acc_last) state_next = S_DIVM;
      end
      S_DIVM: begin
        cmd.div_mean = 1'b1;
        state_next   = S_WAITM;
      end
      S_WAITM: begin
        if (stat.div_done) state_next = S_FIN;
      end
      S_FIN: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_CLEAR;
    endcase
  end

endmodule

>>> rtl/core/dwac_datapath.sv
// History memory, scaling, window sum, mean and colour ramp.
module dwac_datapath
  import dwac_pkg::*;
#(
  parameter int MAX_WINDOW   = 20,
  parameter int FRAME_PIXELS = 307200
) (
  input  logic                 clk,
  input  logic                 rst,
  input  dwac_cmd_t            cmd,
  output dwac_stat_t           stat,
  input  pix_in_t              in_item,
  input  logic                 cfg_valid,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [PIX_W-1:0]     cfg_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output pix_out_t             out_item
);

  localparam int SLOT_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int ADDR_W = (FRAME_PIXELS > 1) ? $clog2(FRAME_PIXELS) : 1;
  localparam int CNT_W  = $clog2(MAX_WINDOW + 1);
  localparam int SUM_W  = $clog2(MAX_WINDOW * 255 + 1);
  localparam int ROW_W  = MAX_WINDOW * PIX_W;

  // configuration registers
  logic [PIX_W-1:0] far_level, near_level, water_top, grass_band, hill_band;
  logic [WIN_W-1:0] window_frames;
  logic             colour_mode;

  always_ff @(posedge clk) begin
    if (rst) begin
      far_level     <= FAR_RST;
      near_level    <= NEAR_RST;
      window_frames <= WIN_RST;
      water_top     <= WATER_RST;
      grass_band    <= GRASS_RST;
      hill_band     <= HILL_RST;
      colour_mode   <= MODE_RST;
    end else if (cfg_valid) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_FAR:   far_level     <= cfg_data;
        CFG_NEAR:  near_level    <= cfg_data;
        CFG_WIN:   window_frames <= cfg_data[WIN_W-1:0];
        CFG_WATER: water_top     <= cfg_data;
        CFG_GRASS: grass_band    <= cfg_data;
        CFG_HILL:  hill_band     <= cfg_data;
        CFG_MODE:  colour_mode   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // clearing sweep and frame slot
  logic [ADDR_W-1:0] clr_addr;
  logic [SLOT_W-1:0] newest_slot;
  logic [SLOT_W-1:0] slot;

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr    <= '0;
      newest_slot <= '0;
    end else begin
      if (cmd.clr_step) clr_addr <= clr_addr + 1'b1;
      if (cmd.take && in_item.frame_end) begin
        newest_slot <= (newest_slot == SLOT_W'(MAX_WINDOW - 1)) ? '0
                                                                : newest_slot + 1'b1;
      end
    end
  end

  assign stat.clr_last = (clr_addr == ADDR_W'(FRAME_PIXELS - 1));

  // captured item
  logic [PIX_W-1:0]     depth;
  logic [POS_CMP_W-1:0] pos_ext;
  logic [ADDR_W-1:0]    addr;

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      depth   <= in_item.depth_raw;
      pos_ext <= POS_CMP_W'(in_item.pixel_pos);
      slot    <= newest_slot;
    end
  end

  assign addr        = pos_ext[ADDR_W-1:0];
  assign stat.pos_ok = pos_ext < POS_CMP_W'(FRAME_PIXELS);

  // scaling operands
  logic                 in_band;
  logic [PIX_W-1:0]     diff;
  logic [DIV_NUM_W-1:0] scale_num;
  logic [DIV_DEN_W-1:0] scale_den;

  assign in_band   = (depth >= far_level) && (depth <= near_level) &&
                     (near_level > far_level);
  assign diff      = depth - far_level;
  assign scale_num = in_band ? DIV_NUM_W'(DIV_NUM_W'(diff) * DIV_NUM_W'(SCALE_MAX)) : '0;
  assign scale_den = in_band ? DIV_DEN_W'(near_level - far_level) : DIV_DEN_W'(1);

  // effective window length
  logic [WIN_W:0] win6;
  logic [CNT_W-1:0] win_n;

  always_comb begin
    priority if (window_frames == '0)
      win6 = (WIN_W+1)'(1);
    else if ((WIN_W+1)'(window_frames) > (WIN_W+1)'(MAX_WINDOW))
      win6 = (WIN_W+1)'(MAX_WINDOW);
    else
      win6 = (WIN_W+1)'(window_frames);
  end

  assign win_n = CNT_W'(win6);

  // shared divider
  logic [SUM_W-1:0]     sum;
  logic [DIV_NUM_W-1:0] div_num;
  logic [DIV_DEN_W-1:0] div_den;
  logic [PIX_W-1:0]     quot;

  assign div_num = cmd.div_mean ? DIV_NUM_W'(sum) : scale_num;
  assign div_den = cmd.div_mean ? DIV_DEN_W'(win6) : scale_den;

  dwac_divider u_div (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.div_scale | cmd.div_mean),
    .numer (div_num),
    .denom (div_den),
    .done  (stat.div_done),
    .quot  (quot)
  );

  // history memory: one row per pixel, one byte lane per frame slot
  logic [ROW_W-1:0]  hist_mem [FRAME_PIXELS];
  logic [ROW_W-1:0]  row;
  logic [ROW_W-1:0]  row_mod;
  logic [ROW_W-1:0]  wr_row;
  logic [ADDR_W-1:0] wr_addr;
  logic              mem_we;

  always_comb begin
    for (int l = 0; l < MAX_WINDOW; l++) begin
      row_mod[l*PIX_W +: PIX_W] = (SLOT_W'(l) == slot) ? quot : row[l*PIX_W +: PIX_W];
    end
  end

  assign mem_we  = cmd.clr_step | cmd.row_upd;
  assign wr_addr = cmd.clr_step ? clr_addr : addr;
  assign wr_row  = cmd.clr_step ? '0 : row_mod;

  always_ff @(posedge clk) begin
    if (mem_we) hist_mem[wr_addr] <= wr_row;
  end

  always_ff @(posedge clk) begin
    if (cmd.rd) begin
      row <= hist_mem[addr];
    end else if (cmd.row_upd) begin
      row <= row_mod;
    end
  end

  // window accumulation, newest slot backwards
  logic [SLOT_W-1:0] acc_idx;
  logic [CNT_W-1:0]  acc_cnt;
  logic [PIX_W-1:0]  lane;

  assign lane          = row[acc_idx*PIX_W +: PIX_W];
  assign stat.acc_last = (acc_cnt == CNT_W'(1));

  always_ff @(posedge clk) begin
    if (cmd.row_upd) begin
      sum     <= '0;
      acc_idx <= slot;
      acc_cnt <= win_n;
    end else if (cmd.acc_step) begin
      sum     <= sum + SUM_W'(lane);
      acc_idx <= (acc_idx == '0) ? SLOT_W'(MAX_WINDOW - 1) : acc_idx - 1'b1;
      acc_cnt <= acc_cnt - 1'b1;
    end
  end

  // colour ramp on the mean
  logic [PIX_W+1:0] m_ext, b1, b2, b3;
  pix_out_t         ramp_rgb, colour;

  assign m_ext = (PIX_W+2)'(quot);
  assign b1    = (PIX_W+2)'(water_top);
  assign b2    = b1 + (PIX_W+2)'(grass_band);
  assign b3    = b2 + (PIX_W+2)'(hill_band);

  always_comb begin
    priority if (m_ext < b1)                  ramp_rgb = WATER_RGB;
    else if (m_ext > b1 && m_ext < b2)        ramp_rgb = GRASS_RGB;
    else if (m_ext > b2 && m_ext < b3)        ramp_rgb = HILL_RGB;
    else if (m_ext > b3)                      ramp_rgb = PEAK_RGB;
    else                                      ramp_rgb = EDGE_RGB;
  end

  always_comb begin
    priority if (!stat.pos_ok)         colour = BLACK_RGB;
    else if (colour_mode == MODE_GRAY) colour = '{red: quot, green: quot, blue: quot};
    else                               colour = ramp_rgb;
  end

  // output register
  assign stat.out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) out_item <= colour;
  end

endmodule

>>> rtl/core/depth_window_average_colorizer_unit.sv
// One pixel at a time: a new pixel is taken only once the last one's colour is in the output
// register; the shared 8-step divider (scale, then mean) and the one-lane-per-cycle window sum
// set how long each in-frame pixel takes, while an off-frame pixel skips them.
// Reset: synchronous, active high; restores registers, then a clearing sweep
// zeroes all FRAME_PIXELS rows of the history memory with in_ready low (config still taken).
module depth_window_average_colorizer_unit
  import dwac_pkg::*;
#(
  parameter int MAX_WINDOW   = 20,
  parameter int FRAME_PIXELS = 307200
) (
  input  logic                 clk,
  input  logic                 rst,
  // pixel input
  input  logic                 in_valid,
  output logic                 in_ready,
  input  pix_in_t              in_item,
  // colour output
  output logic                 out_valid,
  input  logic                 out_ready,
  output pix_out_t             out_item,
  // configuration writes
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [PIX_W-1:0]     cfg_data
);

  dwac_cmd_t  cmd;
  dwac_stat_t stat;

  // Register writes are always taken, so the port never pushes back.
  assign cfg_ready = 1'b1;

  // Controller: clearing sweep, then per pixel
  //   read row -> scale divide -> write row -> sum W lanes -> mean divide -> output;
  // an off-frame pixel goes from read row straight to output. It waits in the last step only
  // while the output register still holds an untaken result, so a new pixel is taken as soon as that one is loaded.
  dwac_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Datapath: one memory row per pixel holds MAX_WINDOW byte lanes, one
  // per frame slot; the newest slot advances after each frame_end transfer.
  dwac_datapath #(
    .MAX_WINDOW   (MAX_WINDOW),
    .FRAME_PIXELS (FRAME_PIXELS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .in_item   (in_item),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

endmodule

>>> rtl/core/dwac_checker.sv
// Port-level checker for the depth colouriser, bound to the top level.
`include "depth_window_average_colorizer_unit_defines.svh"

module dwac_checker
  import dwac_pkg::*;
(
  input logic                 clk,
  input logic                 rst,
  input logic                 in_valid,
  input logic                 in_ready,
  input logic                 out_valid,
  input logic                 out_ready,
  input pix_out_t             out_item
);

  // stalled result holds
  `DWAC_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_item), "result changed while stalled")

  // one pixel in flight
  `DWAC_ASSERT_NXT(a_busy_after_take, in_valid && in_ready, !in_ready, "second pixel taken while busy")

  // a result never appears straight after a transfer
  `DWAC_ASSERT_NXT(a_no_instant_result, in_valid && in_ready, !$rose(out_valid), "result too early")

  // memory sweep follows reset
  `DWAC_ASSERT_IMP(a_sweep_after_reset, $fell(rst), !in_ready, "input open before clearing sweep")

endmodule

bind depth_window_average_colorizer_unit dwac_checker u_dwac_checker (.*);

>>> bench/tb.sv
// Self-checking bench for the depth window averaging colouriser: table, random frames, scoreboard.
`timescale 1ns / 100ps

module tb;
  import dwac_pkg::*;

  // Block sizing, kept at the values the design is built for.
  localparam int MAX_WIN   = 20;
  localparam int FRAME_PIX = 307200;

  // Register index that maps to no register; a write to it must change nothing.
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 3'd7;

  localparam int PHASES      = 10;
  localparam int PHASE_ITEMS = 200;
  localparam int SETTLE      = 64;       // settling wait, longer than the worst latency of one pixel
  localparam int LONG_HOLD   = 600;      // receiver hold-off, far longer than one pixel
  // Clearing sweep plus 2000 pixels at their slowest, taken several times over.
  localparam int LIMIT       = 3000000;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  pix_in_t              in_item = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  pix_out_t             out_item;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [PIX_W-1:0]     cfg_data = '0;

  depth_window_average_colorizer_unit #(
    .MAX_WINDOW  (MAX_WIN),
    .FRAME_PIXELS(FRAME_PIX)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_item (out_item),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Watchdog
  // ---------------------------------------------------------------------------
  int unsigned cycles = 0;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("** depth_window_average_colorizer_unit: FAILED **");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Colour predictor: own copy of the registers, the history ring and the slot
  // ---------------------------------------------------------------------------
  logic [PIX_W-1:0] far_q   = FAR_RST;
  logic [PIX_W-1:0] near_q  = NEAR_RST;
  logic [WIN_W-1:0] win_q   = WIN_RST;
  logic [PIX_W-1:0] water_q = WATER_RST;
  logic [PIX_W-1:0] grass_q = GRASS_RST;
  logic [PIX_W-1:0] hill_q  = HILL_RST;
  logic             mode_q  = MODE_RST;

  // Sparse history: key is slot * FRAME_PIX + position, a missing key reads zero.
  byte unsigned history_copy [int unsigned];
  int unsigned  newest_slot_q = 0;

  function automatic void apply_write(logic [CFG_IDX_W-1:0] idx, logic [PIX_W-1:0] data);
    case (idx)
      CFG_FAR:   far_q   = data;
      CFG_NEAR:  near_q  = data;
      CFG_WIN:   win_q   = data[WIN_W-1:0];
      CFG_WATER: water_q = data;
      CFG_GRASS: grass_q = data;
      CFG_HILL:  hill_q  = data;
      CFG_MODE:  mode_q  = data[0];
      default: ;
    endcase
  endfunction

  // Works out the colour of one accepted pixel and moves the history on.
  function automatic pix_out_t colour_of_pixel(pix_in_t px);
    int unsigned d, f, nr, pos, n, sum, key, mean, b1, b2, b3, sc;
    pix_out_t    rgb;
    d   = px.depth_raw;
    f   = far_q;
    nr  = near_q;
    pos = px.pixel_pos;
    rgb = BLACK_RGB;
    if (pos < FRAME_PIX) begin
      // empty band (far at or above near) and depths outside it scale to zero
      if (d > nr || d < f || nr <= f) sc = 0;
      else sc = ((d - f) * 255) / (nr - f);
      history_copy[newest_slot_q * FRAME_PIX + pos] = byte'(sc);
      n = win_q;
      if (n < 1) n = 1;
      if (n > MAX_WIN) n = MAX_WIN;
      sum = 0;
      for (int unsigned k = 0; k < n; k++) begin
        key = ((newest_slot_q + MAX_WIN - k) % MAX_WIN) * FRAME_PIX + pos;
        if (history_copy.exists(key)) sum += history_copy[key];
      end
      mean = sum / n;
      if (mode_q == MODE_GRAY) begin
        rgb.red   = mean[7:0];
        rgb.green = mean[7:0];
        rgb.blue  = mean[7:0];
      end else begin
        // band edges summed without wrap; a mean exactly on one shows white
        b1 = water_q;
        b2 = b1 + grass_q;
        b3 = b2 + hill_q;
        if (mean < b1) rgb = WATER_RGB;
        else if (mean > b1 && mean < b2) rgb = GRASS_RGB;
        else if (mean > b2 && mean < b3) rgb = HILL_RGB;
        else if (mean > b3) rgb = PEAK_RGB;
        else rgb = EDGE_RGB;
      end
    end
    // frame end moves the slot on even for an out-of-frame position
    if (px.frame_end) newest_slot_q = (newest_slot_q + 1) % MAX_WIN;
    return rgb;
  endfunction

  // ---------------------------------------------------------------------------
  // Scoreboard on the colour output
  // ---------------------------------------------------------------------------
  pix_out_t    colour_queue [$];
  int unsigned faults = 0;

  function automatic void report_fault(string what, pix_out_t want, pix_out_t got);
    faults++;
    if (faults <= 10)
      $display("%s at cycle %0d: want r%0d g%0d b%0d, got r%0d g%0d b%0d", what, cycles,
               want.red, want.green, want.blue, got.red, got.green, got.blue);
  endfunction

  always @(posedge clk) begin
    pix_out_t want;
    if (!rst && out_valid && out_ready) begin
      if (colour_queue.size() == 0) begin
        report_fault("unexpected colour transfer", BLACK_RGB, out_item);
      end else begin
        want = colour_queue.pop_front();
        if (out_item.red !== want.red || out_item.green !== want.green ||
            out_item.blue !== want.blue)
          report_fault("colour mismatch", want, out_item);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: runs of steady, random, sparse and alternating ready, plus one
  // long hold-off on request so the block backs up into its input.
  // ---------------------------------------------------------------------------
  bit hold_asked = 1'b0;
  bit hold_done  = 1'b0;

  initial begin
    int unsigned style, run;
    @(posedge clk);
    forever begin
      if (hold_asked && !hold_done) begin
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        hold_done = 1'b1;
      end else begin
        style = $urandom_range(0, 3);
        run   = $urandom_range(1, 80);
        for (int unsigned i = 0; i < run; i++) begin
          case (style)
            0: out_ready <= 1'b1;
            1: out_ready <= ($urandom_range(0, 1) == 1);
            2: out_ready <= ($urandom_range(0, 3) == 0);
            default: out_ready <= i[0];
          endcase
          @(posedge clk);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sender side
  // ---------------------------------------------------------------------------
  int unsigned burst_left = 1;

  // One pixel transfer. A typed colour, where given, stands in for the predicted
  // one; the predictor still runs so the history stays in step.
  task automatic offer_pixel(pix_in_t px, bit typed, pix_out_t typed_rgb);
    pix_out_t rgb;
    in_item  <= px;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    rgb = colour_of_pixel(px);
    colour_queue.insert(colour_queue.size(), typed ? typed_rgb : rgb);
    burst_left--;
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(0, 7) == 0 ? 30 : $urandom_range(1, 12)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(50, 150)
                                               : $urandom_range(1, 20);
    end
  endtask

  // Stop offering and wait until every colour is back and the block is quiet.
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (colour_queue.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Register write transfer; valid is left high so writes run back to back.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [PIX_W-1:0] data);
    cfg_index <= idx;
    cfg_data  <= data;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    apply_write(idx, data);
  endtask

  // Depth mostly inside the kept band, sometimes anywhere.
  function automatic logic [PIX_W-1:0] pick_depth();
    if ($urandom_range(0, 4) == 0) return PIX_W'($urandom_range(0, 255));
    return PIX_W'($urandom_range(far_q, near_q));
  endfunction

  // ---------------------------------------------------------------------------
  // Directed table
  // ---------------------------------------------------------------------------
  typedef enum logic [1:0] {ROW_PREDICT, ROW_KNOWN, ROW_WRITE} row_kind_t;

  typedef struct packed {
    row_kind_t            kind;
    pix_in_t              px;
    pix_out_t             rgb;
    logic [CFG_IDX_W-1:0] idx;
    logic [PIX_W-1:0]     data;
  } stim_row_t;

  stim_row_t dir_table [$];

  function automatic void add_row(stim_row_t r);
    dir_table.insert(dir_table.size(), r);
  endfunction

  function automatic stim_row_t known(int d, int pos, bit fe, pix_out_t rgb);
    stim_row_t r;
    r = '0;
    r.kind = ROW_KNOWN;
    r.px.depth_raw = d[7:0];
    r.px.pixel_pos = pos[POS_W-1:0];
    r.px.frame_end = fe;
    r.rgb = rgb;
    return r;
  endfunction

  function automatic stim_row_t pred(int d, int pos, bit fe);
    stim_row_t r;
    r = known(d, pos, fe, BLACK_RGB);
    r.kind = ROW_PREDICT;
    return r;
  endfunction

  function automatic stim_row_t wr(logic [CFG_IDX_W-1:0] idx, logic [PIX_W-1:0] data);
    stim_row_t r;
    r = '0;
    r.kind = ROW_WRITE;
    r.idx  = idx;
    r.data = data;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    bit          prev_write;
    int unsigned done_items, pool_n;
    int unsigned pos_pool [$];
    int          set_far, set_near, set_win, set_water, set_grass, set_hill, set_mode;
    pix_in_t     px;

    // After reset: far 150, near 161, window 1, gray.
    add_row(known(161, 0, 0, EDGE_RGB));          // top of band -> 255
    add_row(known(150, FRAME_PIX - 1, 0, BLACK_RGB)); // bottom of band
    add_row(known(0, 1, 0, BLACK_RGB));           // below band
    add_row(known(255, 2, 0, BLACK_RGB));         // above band
    add_row(pred(155, 3, 0));
    add_row(known(200, FRAME_PIX, 1, BLACK_RGB)); // off frame, still ends it
    add_row(known(255, 19'h7FFFF, 0, BLACK_RGB));
    // full band, window above the ring size acts as the full ring
    add_row(wr(CFG_FAR, 8'd0));
    add_row(wr(CFG_NEAR, 8'd255));
    add_row(wr(CFG_WIN, 8'd31));
    add_row(pred(255, 0, 0));
    add_row(pred(170, 19'h2AAAA, 1));
    // ramp with zero water level: an untouched pixel sits on the first edge
    add_row(wr(CFG_WIN, 8'd20));
    add_row(wr(CFG_MODE, 8'd1));
    add_row(wr(CFG_WATER, 8'd0));
    add_row(known(0, 5, 0, EDGE_RGB));
    // empty band, far above near, then far equal to near
    add_row(wr(CFG_FAR, 8'd200));
    add_row(wr(CFG_NEAR, 8'd100));
    add_row(known(150, 6, 0, EDGE_RGB));
    add_row(wr(CFG_FAR, 8'd80));
    add_row(wr(CFG_NEAR, 8'd80));
    add_row(known(80, 7, 1, EDGE_RGB));
    // edges at 100 / 150 / 200, identity scaling, one frame window
    add_row(wr(CFG_FAR, 8'd0));
    add_row(wr(CFG_NEAR, 8'd255));
    add_row(wr(CFG_WIN, 8'd1));
    add_row(wr(CFG_WATER, 8'd100));
    add_row(wr(CFG_GRASS, 8'd50));
    add_row(wr(CFG_HILL, 8'd50));
    add_row(known(50, 8, 0, WATER_RGB));
    add_row(known(100, 8, 0, EDGE_RGB));
    add_row(known(120, 8, 0, GRASS_RGB));
    add_row(known(150, 8, 0, EDGE_RGB));
    add_row(known(170, 8, 0, HILL_RGB));
    add_row(known(200, 8, 0, EDGE_RGB));
    add_row(known(255, 8, 0, PEAK_RGB));
    // all levels at top: edges run past 255 without wrapping
    add_row(wr(CFG_WATER, 8'd255));
    add_row(wr(CFG_GRASS, 8'd255));
    add_row(wr(CFG_HILL, 8'd255));
    add_row(known(255, 9, 0, EDGE_RGB));
    add_row(known(254, 9, 0, WATER_RGB));
    // only low bits count: window 0 acts as 1, mode back to gray; spare index ignored
    add_row(wr(CFG_WIN, 8'hE0));
    add_row(wr(CFG_MODE, 8'hFE));
    add_row(wr(CFG_SPARE, 8'h5A));
    add_row(known(77, FRAME_PIX - 1, 1, '{red: 8'd77, green: 8'd77, blue: 8'd77}));

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Walk the table; writes wait for the block to drain first. The clearing
    // sweep holds in_ready low for a while, which the handshake takes care of.
    prev_write = 1'b0;
    foreach (dir_table[i]) begin
      if (dir_table[i].kind == ROW_WRITE) begin
        if (!prev_write) wait_drained();
        write_reg(dir_table[i].idx, dir_table[i].data);
        prev_write = 1'b1;
      end else begin
        if (prev_write) cfg_valid <= 1'b0;
        offer_pixel(dir_table[i].px, dir_table[i].kind == ROW_KNOWN, dir_table[i].rgb);
        prev_write = 1'b0;
      end
    end

    // Random phases: new settings, then frames over a small pool of positions
    // so the history ring fills and wraps, with stray pixels mixed in.
    for (int phase = 0; phase < PHASES; phase++) begin
      wait_drained();
      set_far   = $urandom_range(0, 255);
      set_near  = $urandom_range(set_far, 255);
      set_win   = $urandom_range(0, 255);
      set_water = $urandom_range(0, 255);
      set_grass = $urandom_range(0, 255);
      set_hill  = $urandom_range(0, 255);
      set_mode  = $urandom_range(0, 255);
      case (phase)
        0: begin
          set_far = 0; set_near = 255; set_win = MAX_WIN; set_mode = 0;
        end
        1: begin
          set_win = 8'hFF; set_mode = 1; set_water = 0; set_grass = 255; set_hill = 255;
        end
        2: set_near = set_far;
        3: begin
          set_far  = $urandom_range(1, 255);
          set_near = $urandom_range(0, set_far - 1);
        end
        4: begin
          set_win = 1; set_water = 255; set_grass = 0; set_hill = 0;
        end
        default: ;
      endcase
      write_reg(CFG_FAR, set_far[7:0]);
      write_reg(CFG_NEAR, set_near[7:0]);
      write_reg(CFG_WIN, set_win[7:0]);
      write_reg(CFG_WATER, set_water[7:0]);
      write_reg(CFG_GRASS, set_grass[7:0]);
      write_reg(CFG_HILL, set_hill[7:0]);
      write_reg(CFG_MODE, set_mode[7:0]);
      cfg_valid <= 1'b0;

      pos_pool.delete();
      pool_n = $urandom_range(1, 6);
      for (int unsigned p = 0; p < pool_n; p++) begin
        case ($urandom_range(0, 9))
          0: pos_pool.insert(pos_pool.size(), 0);
          1: pos_pool.insert(pos_pool.size(), FRAME_PIX - 1);
          default: pos_pool.insert(pos_pool.size(), $urandom_range(0, FRAME_PIX - 1));
        endcase
      end

      // one phase backs up against the long receiver hold-off
      if (phase == 5) hold_asked = 1'b1;

      done_items = 0;
      while (done_items < PHASE_ITEMS) begin
        // once, the sender stops mid-phase until every colour is back
        if (phase == 6 && done_items >= PHASE_ITEMS / 2 && done_items < PHASE_ITEMS / 2 + 8)
        begin
          wait_drained();
          done_items = PHASE_ITEMS / 2 + 8;
        end
        if ($urandom_range(0, 99) < 85) begin
          foreach (pos_pool[p]) begin
            px.depth_raw = pick_depth();
            px.pixel_pos = POS_W'(pos_pool[p]);
            px.frame_end = (p == pos_pool.size() - 1);
            offer_pixel(px, 1'b0, BLACK_RGB);
            done_items++;
          end
        end else begin
          px.depth_raw = PIX_W'($urandom_range(0, 255));
          px.pixel_pos = POS_W'($urandom_range(0, 19'h7FFFF));
          px.frame_end = 1'($urandom_range(0, 1));
          offer_pixel(px, 1'b0, BLACK_RGB);
          done_items++;
        end
      end
    end

    wait_drained();
    if (faults == 0 && colour_queue.size() == 0) begin
      $display("** depth_window_average_colorizer_unit: PASSED **");
    end else begin
      $display("** depth_window_average_colorizer_unit: FAILED **");
    end
    $finish;
  end

endmodule
